FILE: sv/tensor_antisymmetrizer_macros.svh
// Assertion helpers shared by the tensor antisymmetrizer RTL.
`ifndef TENSOR_ANTISYMMETRIZER_MACROS_SVH
`define TENSOR_ANTISYMMETRIZER_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, masked while reset is asserted
`define TSA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also holds during reset
`define TSA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSA_ASSERT(label, clk, rstn, prop, msg)
`define TSA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: sv/tsa_pkg.sv
package tsa_pkg;

    localparam int MAX_RANK_DEF   = 4;
    localparam int MAX_DIM_DEF    = 4;
    localparam int VALUE_BITS_DEF = 32;

    localparam int SLOTS     = 4;     // permutation table covers four slots
    localparam int ADDR_W    = 8;
    localparam int DEPTH     = 256;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 37;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;
    localparam int PERM_N    = 24;
    localparam int PERM_W    = 5;
    localparam int PC_W      = 3;
    localparam int STEPS     = 8;
    localparam int UOP_W     = 3;
    localparam int COND_W    = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TENSOR_RANK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_DIM   = 1'd1;

    localparam logic [CFG_W-1:0] RANK_RESET = 3'd2;
    localparam logic [CFG_W-1:0] DIM_RESET  = 3'd3;

    // micro-operations
    localparam logic [UOP_W-1:0] UOP_IDLE   = 3'd0;
    localparam logic [UOP_W-1:0] UOP_CHECK  = 3'd1;
    localparam logic [UOP_W-1:0] UOP_DIGIT  = 3'd2;
    localparam logic [UOP_W-1:0] UOP_SCREEN = 3'd3;
    localparam logic [UOP_W-1:0] UOP_READ   = 3'd4;
    localparam logic [UOP_W-1:0] UOP_NOP    = 3'd5;
    localparam logic [UOP_W-1:0] UOP_EMIT   = 3'd6;

    // jump conditions
    localparam logic [COND_W-1:0] COND_NEVER       = 3'd0;
    localparam logic [COND_W-1:0] COND_ACCEPT      = 3'd1;
    localparam logic [COND_W-1:0] COND_WRITE       = 3'd2;
    localparam logic [COND_W-1:0] COND_DIGITS_MORE = 3'd3;
    localparam logic [COND_W-1:0] COND_SKIP        = 3'd4;
    localparam logic [COND_W-1:0] COND_PERMS_MORE  = 3'd5;
    localparam logic [COND_W-1:0] COND_OUT_FREE    = 3'd6;

    // program steps
    localparam logic [PC_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [PC_W-1:0] STEP_CHECK  = 3'd1;
    localparam logic [PC_W-1:0] STEP_DIGIT  = 3'd2;
    localparam logic [PC_W-1:0] STEP_SCREEN = 3'd3;
    localparam logic [PC_W-1:0] STEP_READ   = 3'd4;
    localparam logic [PC_W-1:0] STEP_DRAIN  = 3'd5;
    localparam logic [PC_W-1:0] STEP_EMIT   = 3'd6;
    localparam logic [PC_W-1:0] STEP_SPARE  = 3'd7;

    // condition true: go to target; false: stay if hold, else fall through
    typedef struct packed {
        logic [UOP_W-1:0]  uop;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        logic              hold;
    } ctrl_word_t;

    typedef struct packed {
        logic is_write;
        logic digits_more;
        logic skip;
        logic perms_more;
    } dp_status_t;

    localparam ctrl_word_t MICROCODE [STEPS] = '{
        '{UOP_IDLE,   COND_ACCEPT,      STEP_CHECK, 1'b1},
        '{UOP_CHECK,  COND_WRITE,       STEP_IDLE,  1'b0},
        '{UOP_DIGIT,  COND_DIGITS_MORE, STEP_DIGIT, 1'b0},
        '{UOP_SCREEN, COND_SKIP,        STEP_EMIT,  1'b0},
        '{UOP_READ,   COND_PERMS_MORE,  STEP_READ,  1'b0},
        '{UOP_NOP,    COND_NEVER,       STEP_IDLE,  1'b0},
        '{UOP_EMIT,   COND_OUT_FREE,    STEP_IDLE,  1'b1},
        '{UOP_NOP,    COND_NEVER,       STEP_IDLE,  1'b0}
    };

    // {odd, slot3, slot2, slot1, slot0}; the first r! entries permute slots below r
    localparam logic [8:0] PERM_TABLE [PERM_N] = '{
        {1'b0, 2'd3, 2'd2, 2'd1, 2'd0},
        {1'b1, 2'd3, 2'd2, 2'd0, 2'd1},
        {1'b1, 2'd3, 2'd1, 2'd2, 2'd0},
        {1'b0, 2'd3, 2'd0, 2'd2, 2'd1},
        {1'b0, 2'd3, 2'd1, 2'd0, 2'd2},
        {1'b1, 2'd3, 2'd0, 2'd1, 2'd2},
        {1'b1, 2'd2, 2'd3, 2'd1, 2'd0},
        {1'b0, 2'd2, 2'd1, 2'd3, 2'd0},
        {1'b0, 2'd2, 2'd3, 2'd0, 2'd1},
        {1'b1, 2'd2, 2'd0, 2'd3, 2'd1},
        {1'b1, 2'd2, 2'd1, 2'd0, 2'd3},
        {1'b0, 2'd2, 2'd0, 2'd1, 2'd3},
        {1'b0, 2'd1, 2'd3, 2'd2, 2'd0},
        {1'b1, 2'd1, 2'd2, 2'd3, 2'd0},
        {1'b1, 2'd1, 2'd3, 2'd0, 2'd2},
        {1'b0, 2'd1, 2'd0, 2'd3, 2'd2},
        {1'b0, 2'd1, 2'd2, 2'd0, 2'd3},
        {1'b1, 2'd1, 2'd0, 2'd2, 2'd3},
        {1'b1, 2'd0, 2'd3, 2'd2, 2'd1},
        {1'b0, 2'd0, 2'd2, 2'd3, 2'd1},
        {1'b0, 2'd0, 2'd3, 2'd1, 2'd2},
        {1'b1, 2'd0, 2'd1, 2'd3, 2'd2},
        {1'b1, 2'd0, 2'd2, 2'd1, 2'd3},
        {1'b0, 2'd0, 2'd1, 2'd2, 2'd3}
    };

    // base^expo for expo up to four
    function automatic logic [8:0] pow_of(input logic [2:0] base, input logic [2:0] expo);
        logic [8:0] acc;
        acc = 9'd1;
        for (int i = 0; i < SLOTS; i++) begin
            if (3'(i) < expo) begin
                acc = 9'(acc * 9'(base));
            end
        end
        return acc;
    endfunction

    function automatic logic [PERM_W-1:0] perm_count(input logic [2:0] rank);
        logic [PERM_W-1:0] n;
        case (rank)
            3'd0, 3'd1: n = 5'd1;
            3'd2:       n = 5'd2;
            3'd3:       n = 5'd6;
            default:    n = 5'd24;
        endcase
        return n;
    endfunction

endpackage

FILE: sv/tsa_sequencer.sv
`include "tensor_antisymmetrizer_macros.svh"

module tsa_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tsa_pkg::dp_status_t  status,
    input  logic                 accept,
    input  logic                 out_free,
    output tsa_pkg::ctrl_word_t  ctrl
);

    logic [tsa_pkg::PC_W-1:0] pc_reg;
    logic [tsa_pkg::PC_W-1:0] pc_next;
    logic                     cond_hit;

    assign ctrl = tsa_pkg::MICROCODE[pc_reg];

    always_comb begin
        case (ctrl.cond)
            tsa_pkg::COND_ACCEPT:      cond_hit = accept;
            tsa_pkg::COND_WRITE:       cond_hit = status.is_write;
            tsa_pkg::COND_DIGITS_MORE: cond_hit = status.digits_more;
            tsa_pkg::COND_SKIP:        cond_hit = status.skip;
            tsa_pkg::COND_PERMS_MORE:  cond_hit = status.perms_more;
            tsa_pkg::COND_OUT_FREE:    cond_hit = out_free;
            default:                   cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (cond_hit) begin
            pc_next = ctrl.target;
        end else if (ctrl.hold) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= tsa_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    `TSA_ASSERT(a_accept_to_check, aclk, aresetn, (ctrl.uop == tsa_pkg::UOP_IDLE && accept) |=> (pc_reg == tsa_pkg::STEP_CHECK), "accepted request did not start the check step")

endmodule

FILE: sv/tsa_datapath.sv
`include "tensor_antisymmetrizer_macros.svh"

module tsa_datapath #(
    parameter int MAX_RANK   = tsa_pkg::MAX_RANK_DEF,
    parameter int MAX_DIM    = tsa_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = tsa_pkg::VALUE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [tsa_pkg::UOP_W-1:0]         uop,
    input  logic                              accept,
    input  logic                              s_op,
    input  logic [tsa_pkg::ADDR_W-1:0]        s_comp_index,
    input  logic signed [tsa_pkg::IN_W-1:0]   s_comp_value,
    input  logic [tsa_pkg::CFG_W-1:0]         rank_eff,
    input  logic [tsa_pkg::CFG_W-1:0]         dim_eff,
    output tsa_pkg::dp_status_t               status,
    output logic signed [tsa_pkg::OUT_W-1:0]  acc,
    output logic                              err
);

    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int KW    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int VIN_W = (VALUE_BITS > tsa_pkg::IN_W) ? VALUE_BITS : tsa_pkg::IN_W;
    localparam int EXT_W = (VALUE_BITS > tsa_pkg::OUT_W) ? VALUE_BITS : tsa_pkg::OUT_W;
    localparam logic [15:0] DIV3_MUL   = 16'd171;   // floor(x/3) = x*171 >> 9 for x < 256
    localparam int          DIV3_SHIFT = 9;

    logic signed [VALUE_BITS-1:0] mem [tsa_pkg::DEPTH];

    logic                              op_reg;
    logic [tsa_pkg::ADDR_W-1:0]        idx_reg;
    logic signed [VALUE_BITS-1:0]      val_reg;
    logic [tsa_pkg::ADDR_W-1:0]        rem_reg;
    logic [KW-1:0]                     k_reg;
    logic [DW-1:0]                     digit_reg [MAX_RANK];
    logic                              err_reg;
    logic [tsa_pkg::PERM_W-1:0]        p_reg;
    logic                              pend_reg;
    logic                              neg_reg;
    logic signed [VALUE_BITS-1:0]      mem_q_reg;
    logic signed [tsa_pkg::OUT_W-1:0]  acc_reg;
    logic signed [tsa_pkg::OUT_W-1:0]  acc_next;

    logic signed [VIN_W-1:0]           v_ext;
    logic signed [EXT_W-1:0]           q_ext;
    logic [8:0]                        count;
    logic                              in_range;
    logic [tsa_pkg::ADDR_W-1:0]        div3;
    logic [tsa_pkg::ADDR_W-1:0]        quo;
    logic [tsa_pkg::ADDR_W-1:0]        rmd;
    logic [8:0]                        weight [MAX_RANK];
    logic [8:0]                        perm_word;
    logic [1:0]                        lin_slot;
    logic [DW-1:0]                     lin_sel;
    logic [9:0]                        lin_sum;
    logic [tsa_pkg::ADDR_W-1:0]        rd_addr;
    logic                              repeated;
    logic                              mem_we;
    logic                              mem_re;

    assign v_ext = VIN_W'(s_comp_value);
    assign q_ext = EXT_W'(mem_q_reg);

    assign count    = tsa_pkg::pow_of(dim_eff, rank_eff);
    assign in_range = {1'b0, idx_reg} < count;

    // one base-dim digit per step
    assign div3 = tsa_pkg::ADDR_W'((16'(rem_reg) * DIV3_MUL) >> DIV3_SHIFT);

    always_comb begin
        case (dim_eff)
            3'd2: begin
                quo = {1'b0, rem_reg[7:1]};
                rmd = {7'b0, rem_reg[0]};
            end
            3'd3: begin
                quo = div3;
                rmd = rem_reg - tsa_pkg::ADDR_W'(10'(div3) * 10'd3);
            end
            3'd4: begin
                quo = {2'b0, rem_reg[7:2]};
                rmd = {6'b0, rem_reg[1:0]};
            end
            default: begin
                quo = rem_reg;
                rmd = '0;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < MAX_RANK; i++) begin
            weight[i] = tsa_pkg::pow_of(dim_eff, 3'(i));
        end
    end

    // component address for the current permutation
    assign perm_word = tsa_pkg::PERM_TABLE[p_reg];

    always_comb begin
        lin_sum  = '0;
        lin_slot = '0;
        lin_sel  = '0;
        for (int i = 0; i < MAX_RANK; i++) begin
            lin_slot = perm_word[2*i +: 2];
            lin_sel  = '0;
            for (int j = 0; j < MAX_RANK; j++) begin
                if (lin_slot == 2'(j)) begin
                    lin_sel = digit_reg[j];
                end
            end
            if (3'(i) < rank_eff) begin
                lin_sum = lin_sum + 10'(10'(lin_sel) * 10'(weight[i]));
            end
        end
    end

    assign rd_addr = lin_sum[tsa_pkg::ADDR_W-1:0];

    always_comb begin
        repeated = 1'b0;
        for (int i = 0; i < MAX_RANK; i++) begin
            for (int j = i + 1; j < MAX_RANK; j++) begin
                if (3'(j) < rank_eff && digit_reg[i] == digit_reg[j]) begin
                    repeated = 1'b1;
                end
            end
        end
    end

    assign status.is_write    = !op_reg;
    assign status.digits_more = (4'(k_reg) + 4'd1) < {1'b0, rank_eff};
    assign status.skip        = err_reg || repeated || (rank_eff > dim_eff);
    assign status.perms_more  = (6'(p_reg) + 6'd1) < 6'(tsa_pkg::perm_count(rank_eff));

    assign mem_we = (uop == tsa_pkg::UOP_CHECK) && !op_reg && in_range;
    assign mem_re = (uop == tsa_pkg::UOP_READ);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[idx_reg] <= val_reg;
        end
        if (mem_re) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        if (neg_reg) begin
            acc_next = acc_reg - q_ext[tsa_pkg::OUT_W-1:0];
        end else begin
            acc_next = acc_reg + q_ext[tsa_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_op;
            idx_reg <= s_comp_index;
            val_reg <= v_ext[VALUE_BITS-1:0];
        end
        case (uop)
            tsa_pkg::UOP_CHECK: begin
                err_reg <= !in_range;
                rem_reg <= idx_reg;
                k_reg   <= '0;
                p_reg   <= '0;
            end
            tsa_pkg::UOP_DIGIT: begin
                for (int j = 0; j < MAX_RANK; j++) begin
                    if (k_reg == KW'(j)) begin
                        digit_reg[j] <= DW'(rmd);
                    end
                end
                rem_reg <= quo;
                if (status.digits_more) begin
                    k_reg <= k_reg + KW'(1);
                end
            end
            tsa_pkg::UOP_READ: begin
                neg_reg <= perm_word[8];
                if (status.perms_more) begin
                    p_reg <= p_reg + 5'd1;
                end
            end
            default: ;
        endcase
        if (uop == tsa_pkg::UOP_CHECK) begin
            acc_reg <= '0;
        end else if (pend_reg) begin
            acc_reg <= acc_next;
        end
    end

    // read data lands in the cycle after the address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= mem_re;
        end
    end

    assign acc = acc_reg;
    assign err = err_reg;

    `TSA_ASSERT(a_pend_after_read, aclk, aresetn, pend_reg |-> $past(uop == tsa_pkg::UOP_READ), "accumulate without a preceding component read")
    `TSA_ASSERT(a_read_only_valid, aclk, aresetn, (uop == tsa_pkg::UOP_READ) |-> (!err_reg && !repeated && rank_eff <= dim_eff), "component read on a request that must give zero")

endmodule

FILE: sv/tensor_antisymmetrizer.sv
// Tensor antisymmetrizer: holds one tensor of rank tensor_rank (0..4) over
// dimension space_dim (1..4) as up to 256 Q16.16 components. A write request
// (op 0) stores comp_value at comp_index and gives no result; indices at or
// beyond space_dim^tensor_rank are dropped. A read request (op 1) gives one
// result: the signed sum over all rank! slot permutations of the stored
// component at the permuted index, zero when index digits repeat or the rank
// exceeds the dimension, and index_error with a zero value when the index is
// out of range. Requests are handled one at a time by a small microcode
// program. A write runs only the check step and then returns to idle. A read
// runs the check step, one digit step per slot (at least one), the screen
// step, then one read step per permutation, one permutation per cycle through
// the single component memory read port, and the drain step; it loads its
// result in the emit step. Reads that resolve to zero go from the screen step
// straight to emit. The next request can be taken in the cycle after the
// result is loaded; a full output register holds the program in its emit
// step. A finished result waits in the output register while the next
// request is taken. Components are undefined until written; reading one
// never written gives an undefined value. Configuration must be written by the
// user only while the block is idle; the block itself does not enforce it.
`include "tensor_antisymmetrizer_macros.svh"

module tensor_antisymmetrizer #(
    parameter int MAX_RANK   = tsa_pkg::MAX_RANK_DEF,
    parameter int MAX_DIM    = tsa_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = tsa_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsa_pkg::CFG_W-1:0]           cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [tsa_pkg::ADDR_W-1:0]          s_comp_index,
    input  logic signed [tsa_pkg::IN_W-1:0]     s_comp_value,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tsa_pkg::OUT_W-1:0]    m_alt_value,
    output logic                                m_index_error
);

    logic [tsa_pkg::CFG_W-1:0]         tensor_rank_reg;
    logic [tsa_pkg::CFG_W-1:0]         space_dim_reg;
    logic [tsa_pkg::CFG_W-1:0]         rank_eff;
    logic [tsa_pkg::CFG_W-1:0]         dim_eff;

    logic                              m_valid_reg;
    logic signed [tsa_pkg::OUT_W-1:0]  m_alt_value_reg;
    logic                              m_index_error_reg;

    tsa_pkg::ctrl_word_t               ctrl;
    tsa_pkg::dp_status_t               status;
    logic                              accept;
    logic                              out_free;
    logic                              emit_load;
    logic signed [tsa_pkg::OUT_W-1:0]  acc;
    logic                              err;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tensor_rank_reg <= tsa_pkg::RANK_RESET;
            space_dim_reg   <= tsa_pkg::DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tsa_pkg::REG_TENSOR_RANK: tensor_rank_reg <= cfg_data;
                tsa_pkg::REG_SPACE_DIM:   space_dim_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // out-of-range settings fold onto the nearest supported value
    assign rank_eff = (tensor_rank_reg > 3'(MAX_RANK)) ? 3'(MAX_RANK) : tensor_rank_reg;
    assign dim_eff  = (space_dim_reg == '0)           ? 3'd1 :
                      (space_dim_reg > 3'(MAX_DIM))   ? 3'(MAX_DIM) : space_dim_reg;

    assign s_ready   = (ctrl.uop == tsa_pkg::UOP_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_load = (ctrl.uop == tsa_pkg::UOP_EMIT) && out_free;

    tsa_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (status),
        .accept   (accept),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    tsa_datapath #(
        .MAX_RANK   (MAX_RANK),
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .uop          (ctrl.uop),
        .accept       (accept),
        .s_op         (s_op),
        .s_comp_index (s_comp_index),
        .s_comp_value (s_comp_value),
        .rank_eff     (rank_eff),
        .dim_eff      (dim_eff),
        .status       (status),
        .acc          (acc),
        .err          (err)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_alt_value_reg   <= acc;
            m_index_error_reg <= err;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_alt_value   = m_alt_value_reg;
    assign m_index_error = m_index_error_reg;

    `TSA_ASSERT(a_accept_leaves_idle, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "request accepted twice in a row")
    `TSA_ASSERT(a_result_from_emit, aclk, aresetn, $rose(m_valid) |-> $past(ctrl.uop == tsa_pkg::UOP_EMIT), "result raised outside the emit step")

endmodule

FILE: bench/tensor_antisymmetrizer_tb.sv
`timescale 1ns / 1ps

module tensor_antisymmetrizer_tb;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 40;    // longer than the longest read, after the last result

    typedef struct packed {
        logic signed [tsa_pkg::OUT_W-1:0] alt_value;
        logic                             index_error;
    } alt_result_t;

    logic                              aclk;
    logic                              aresetn       = 1'b0;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    logic [tsa_pkg::CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [tsa_pkg::CFG_W-1:0]         cfg_data      = '0;
    logic                              s_valid       = 1'b0;
    logic                              s_ready;
    logic                              s_op          = 1'b0;
    logic [tsa_pkg::ADDR_W-1:0]        s_comp_index  = '0;
    logic signed [tsa_pkg::IN_W-1:0]   s_comp_value  = '0;
    logic                              m_valid;
    logic                              m_ready       = 1'b0;
    logic signed [tsa_pkg::OUT_W-1:0]  m_alt_value;
    logic                              m_index_error;

    // shadow copy of the block's state
    logic signed [tsa_pkg::IN_W-1:0]   shadow_components [tsa_pkg::DEPTH];
    logic [tsa_pkg::CFG_W-1:0]         shape_rank = tsa_pkg::RANK_RESET;
    logic [tsa_pkg::CFG_W-1:0]         shape_dim  = tsa_pkg::DIM_RESET;
    alt_result_t                       pending_alt_q [$];
    alt_result_t                       oldest_alt;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int failures      = 0;
    int writes_sent   = 0;
    int reads_sent    = 0;
    int range_errors  = 0;
    int results_seen  = 0;
    int shapes_used   = 0;

    tensor_antisymmetrizer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_comp_index  (s_comp_index),
        .s_comp_value  (s_comp_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_alt_value   (m_alt_value),
        .m_index_error (m_index_error)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int active_rank();
        return (shape_rank > 3'(tsa_pkg::MAX_RANK_DEF)) ? tsa_pkg::MAX_RANK_DEF
                                                         : int'(shape_rank);
    endfunction

    function automatic int active_dim();
        if (shape_dim == 3'd0) begin
            return 1;
        end
        return (shape_dim > 3'(tsa_pkg::MAX_DIM_DEF)) ? tsa_pkg::MAX_DIM_DEF
                                                       : int'(shape_dim);
    endfunction

    function automatic int component_count();
        int n;
        n = 1;
        for (int i = 0; i < active_rank(); i++) begin
            n *= active_dim();
        end
        return n;
    endfunction

    // signed sum over all slot permutations of the shadow tensor
    function automatic alt_result_t alternated_component(
            input logic [tsa_pkg::ADDR_W-1:0] idx);
        alt_result_t                      res;
        logic signed [tsa_pkg::OUT_W-1:0] acc;
        logic signed [tsa_pkg::IN_W-1:0]  v;
        int  r, d, rem, codes, inv, lin, stride;
        int  dig [tsa_pkg::SLOTS];
        int  perm [tsa_pkg::SLOTS];
        logic [tsa_pkg::SLOTS-1:0] used;
        bit  repeated, ok;
        r = active_rank();
        d = active_dim();
        res.alt_value = '0;
        res.index_error = 1'b0;
        if (int'(idx) >= component_count()) begin
            res.index_error = 1'b1;
            return res;
        end
        rem = idx;
        for (int i = 0; i < r; i++) begin
            dig[i] = rem % d;
            rem = rem / d;
        end
        repeated = 1'b0;
        for (int i = 0; i < r; i++) begin
            for (int j = i + 1; j < r; j++) begin
                if (dig[i] == dig[j]) repeated = 1'b1;
            end
        end
        acc = '0;
        if (!repeated && r <= d) begin
            codes = 1;
            for (int i = 0; i < r; i++) codes *= r;
            for (int code = 0; code < codes; code++) begin
                rem = code;
                used = '0;
                ok = 1'b1;
                for (int i = 0; i < r; i++) begin
                    perm[i] = rem % r;
                    rem = rem / r;
                    if (used[perm[i]]) ok = 1'b0;
                    used[perm[i]] = 1'b1;
                end
                if (ok) begin
                    inv = 0;
                    for (int i = 0; i < r; i++) begin
                        for (int j = i + 1; j < r; j++) begin
                            if (perm[i] > perm[j]) inv++;
                        end
                    end
                    lin = 0;
                    stride = 1;
                    for (int i = 0; i < r; i++) begin
                        lin += dig[perm[i]] * stride;
                        stride *= d;
                    end
                    v = shadow_components[lin % tsa_pkg::DEPTH];
                    if (inv % 2 == 1) begin
                        acc = acc - {{(tsa_pkg::OUT_W-tsa_pkg::IN_W){v[tsa_pkg::IN_W-1]}}, v};
                    end else begin
                        acc = acc + {{(tsa_pkg::OUT_W-tsa_pkg::IN_W){v[tsa_pkg::IN_W-1]}}, v};
                    end
                end
            end
        end
        res.alt_value = acc;
        return res;
    endfunction

    function automatic logic signed [tsa_pkg::IN_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4) return 32'sh7fffffff;
        if (roll < 8) return 32'sh80000000;
        if (roll < 10) return '0;
        if (roll < 12) return -32'sd1;
        return $urandom();
    endfunction

    // index whose digits are all distinct under the current shape
    function automatic logic [tsa_pkg::ADDR_W-1:0] distinct_digit_index();
        int pool [tsa_pkg::SLOTS];
        int r, d, j, tmp, lin, stride;
        r = active_rank();
        d = active_dim();
        for (int i = 0; i < tsa_pkg::SLOTS; i++) pool[i] = i;
        for (int i = d - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        lin = 0;
        stride = 1;
        for (int i = 0; i < r; i++) begin
            lin += pool[i] * stride;
            stride *= d;
        end
        return tsa_pkg::ADDR_W'(lin);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic op, input logic [tsa_pkg::ADDR_W-1:0] idx,
                                input logic signed [tsa_pkg::IN_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_op         = op;
        s_comp_index = idx;
        s_comp_value = val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_WRITE) begin
            if (int'(idx) < component_count()) shadow_components[idx] = val;
            writes_sent++;
        end else begin
            pending_alt_q.insert(pending_alt_q.size(), alternated_component(idx));
            if (int'(idx) >= component_count()) range_errors++;
            reads_sent++;
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_alt_q.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [tsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tsa_pkg::CFG_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == tsa_pkg::REG_TENSOR_RANK) begin
            shape_rank = data;
        end else begin
            shape_dim = data;
        end
        @(negedge aclk);
    endtask

    task automatic set_shape(input logic [tsa_pkg::CFG_W-1:0] rank,
                             input logic [tsa_pkg::CFG_W-1:0] dim);
        wait_drained();
        // writes give no result, so let any trailing request finish
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(tsa_pkg::REG_TENSOR_RANK, rank);
        write_reg(tsa_pkg::REG_SPACE_DIM, dim);
        cfg_valid = 1'b0;
        shapes_used++;
    endtask

    // reset shape is rank 2 over dim 3; only entries 5 and 7 get touched
    task automatic test_reset_shape();
        send_request(OP_WRITE, 8'd5, 32'sh00018000);
        send_request(OP_WRITE, 8'd7, -32'sh00004000);
        send_request(OP_READ, 8'd5, $urandom());
        send_request(OP_READ, 8'd7, $urandom());
        send_request(OP_READ, 8'd4, $urandom());   // digits 1,1
        send_request(OP_READ, 8'd9, $urandom());   // first out-of-range index
    endtask

    // fill every entry; distinct-digit entries get max or min by parity so the
    // full alternation reaches both ends of the output range
    task automatic test_fill_store();
        logic [1:0] dg [tsa_pkg::SLOTS];
        int  inv;
        bit  distinct;
        set_shape(3'd4, 3'd4);
        for (int idx = 0; idx < tsa_pkg::DEPTH; idx++) begin
            for (int i = 0; i < tsa_pkg::SLOTS; i++) dg[i] = 2'(idx >> (2 * i));
            distinct = 1'b1;
            inv = 0;
            for (int i = 0; i < tsa_pkg::SLOTS; i++) begin
                for (int j = i + 1; j < tsa_pkg::SLOTS; j++) begin
                    if (dg[i] == dg[j]) distinct = 1'b0;
                    if (dg[i] > dg[j]) inv++;
                end
            end
            if (!distinct) begin
                send_request(OP_WRITE, tsa_pkg::ADDR_W'(idx), pick_value());
            end else if (inv % 2 == 0) begin
                send_request(OP_WRITE, tsa_pkg::ADDR_W'(idx), 32'sh7fffffff);
            end else begin
                send_request(OP_WRITE, tsa_pkg::ADDR_W'(idx), 32'sh80000000);
            end
        end
    endtask

    task automatic test_extreme_sums();
        send_request(OP_READ, 8'd228, 32'sh7fffffff);  // digits 0,1,2,3
        send_request(OP_READ, 8'd225, 32'sh80000000);  // digits 1,0,2,3
        send_request(OP_READ, 8'd0, $urandom());
        send_request(OP_READ, 8'd255, $urandom());
    endtask

    task automatic test_small_shapes();
        set_shape(3'd0, 3'd4);                 // rank zero: single component
        send_request(OP_READ, 8'd0, $urandom());
        send_request(OP_READ, 8'd1, $urandom());
        set_shape(3'd1, 3'd1);
        send_request(OP_READ, 8'd0, $urandom());
        send_request(OP_READ, 8'd1, $urandom());
        set_shape(3'd3, 3'd4);
        send_request(OP_READ, distinct_digit_index(), $urandom());
        send_request(OP_READ, 8'd63, $urandom());
        send_request(OP_READ, 8'd64, $urandom());
        set_shape(3'd4, 3'd2);                 // rank above dim
        send_request(OP_READ, 8'd6, $urandom());
        send_request(OP_READ, 8'd16, $urandom());
        set_shape(3'd7, 3'd7);                 // both clamp to 4
        send_request(OP_READ, 8'd228, $urandom());
        set_shape(3'd5, 3'd0);                 // rank 4 over dim 1
        send_request(OP_READ, 8'd0, $urandom());
        send_request(OP_READ, 8'd1, $urandom());
        set_shape(3'd2, 3'd6);
        send_request(OP_READ, distinct_digit_index(), $urandom());
    endtask

    task automatic test_ignored_write();
        set_shape(3'd1, 3'd2);
        send_request(OP_WRITE, 8'd200, 32'sh12345678);  // out of range, dropped
        send_request(OP_WRITE, 8'd1, -32'sh00010000);
        send_request(OP_READ, 8'd200, $urandom());
        send_request(OP_READ, 8'd1, $urandom());
    endtask

    // output held off while reads keep coming, then writes and reads interleaved
    task automatic test_backpressure();
        set_shape(3'd4, 3'd4);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        for (int n = 0; n < 8; n++) begin
            send_request(OP_READ, distinct_digit_index(), $urandom());
        end
        wait_drained();
        for (int n = 0; n < 4; n++) begin
            send_request(OP_WRITE, 8'($urandom()), pick_value());
            send_request(OP_READ, distinct_digit_index(), $urandom());
        end
        wait_drained();
    endtask

    task automatic test_random(input int mode, input int per_shape);
        int roll, cnt;
        logic [tsa_pkg::CFG_W-1:0] r, d;
        logic [tsa_pkg::ADDR_W-1:0] idx;
        case (mode)
            0: begin
                send_idle_pct = 35;
                recv_idle_pct = 80;
            end
            1: begin
                send_idle_pct = 80;
                recv_idle_pct = 35;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
        for (int chunk = 0; chunk < 4; chunk++) begin
            if (chunk == 0) begin
                set_shape(3'd4, 3'd4);
            end else if ($urandom_range(99) < 20) begin
                set_shape(3'($urandom()), 3'($urandom()));
            end else begin
                d = 3'($urandom_range(4, 1));
                r = 3'($urandom_range(d, 0));
                set_shape(r, d);
            end
            cnt = component_count();
            for (int n = 0; n < per_shape; n++) begin
                roll = $urandom_range(99);
                if (roll < 40) begin
                    if ($urandom_range(99) < 85) begin
                        idx = tsa_pkg::ADDR_W'($urandom_range(cnt - 1));
                    end else begin
                        idx = 8'($urandom());
                    end
                    send_request(OP_WRITE, idx, pick_value());
                end else begin
                    roll = $urandom_range(99);
                    if (roll < 60 && active_rank() <= active_dim()) begin
                        idx = distinct_digit_index();
                    end else if (roll < 85) begin
                        idx = tsa_pkg::ADDR_W'($urandom_range(cnt - 1));
                    end else begin
                        idx = 8'($urandom());
                    end
                    send_request(OP_READ, idx, $urandom());
                end
            end
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_alt_q.size() == 0) begin
                $error("result with nothing pending: alt_value %0d index_error %0b",
                       m_alt_value, m_index_error);
                failures++;
            end else begin
                oldest_alt = pending_alt_q.pop_front();
                if (m_alt_value !== oldest_alt.alt_value) begin
                    $error("alt_value: expected %0d, got %0d",
                           oldest_alt.alt_value, m_alt_value);
                    failures++;
                end
                if (m_index_error !== oldest_alt.index_error) begin
                    $error("index_error: expected %0b, got %0b",
                           oldest_alt.index_error, m_index_error);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     STALL_LIMIT, pending_alt_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_shape();
        test_fill_store();
        test_extreme_sums();
        test_small_shapes();
        test_ignored_write();
        test_backpressure();
        test_random(0, 45);
        test_random(1, 45);
        test_random(2, 45);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (pending_alt_q.size() != 0) begin
            $error("%0d expected results never arrived", pending_alt_q.size());
            failures++;
        end
        $display("run: %0d writes, %0d reads (%0d out of range), %0d results checked",
                 writes_sent, reads_sent, range_errors, results_seen);
        $display("run: %0d shape settings, stalls on both sides, %0d failures",
                 shapes_used, failures);
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: tensor_antisymmetrizer.f
+incdir+sv
sv/tsa_pkg.sv
sv/tsa_sequencer.sv
sv/tsa_datapath.sv
sv/tensor_antisymmetrizer.sv
bench/tensor_antisymmetrizer_tb.sv
